// ===== rtl/core/timed_event_queue_core_defines.svh =====
// Assertion macros for the timed event queue core.
// The asserting module must provide aclk and aresetn.
`ifndef TIMED_EVENT_QUEUE_CORE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TEQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/teq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_COUNT    = 64;
    localparam int MAX_RESULTS = 16;

    localparam int KIND_W = 3;
    localparam int CYC_W  = 31;
    localparam int TIME_W = 64;
    localparam int ID_W   = 6;
    localparam int QCNT_W = 5;
    localparam int RUN_CNT_W = $clog2(MAX_RESULTS);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_CANCEL = 3'd2,
        KIND_RUN    = 3'd3,
        KIND_SET    = 3'd4,
        KIND_CLEAR  = 3'd5,
        KIND_RESET  = 3'd6
    } teq_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CYC_W-1:0]  cycles;
        logic [TIME_W-1:0] delay;
        logic [ID_W-1:0]   event_id;
        logic [TIME_W-1:0] new_time;
    } teq_in_t;

    typedef struct packed {
        logic              fired_valid;
        logic [ID_W-1:0]   fired_id;
        logic              last;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] next_time;
        logic [QCNT_W-1:0] queue_count;
        logic              overflow;
        logic              cancel_hit;
    } teq_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CANCEL,
        ST_RUN
    } teq_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic apply;
        logic remove_one;
        logic pop;
        logic emit;
        logic fired;
        logic last;
    } teq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic head_due;
        logic second_due;
        logic match_any;
    } teq_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/timed_event_queue_core.sv =====
// An item is taken in the idle state; tick, add, set, clear and reset are applied in the execute
// state once the result register is free; only after this idle/execute pass is the next item taken.
// Cancel removes matching entries one per cycle through the shifting row, then reports.
// Run fires at most 16 due events, one pop per output slot, each slot waiting for a free result.
// Reset (aresetn low, synchronous) clears time, pending count and handshake state;
// queue entries keep their contents and are never read beyond the pending count.
`timescale 1ns / 1ps
`default_nettype none
`include "timed_event_queue_core_defines.svh"

module timed_event_queue_core #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH,
    parameter int ID_COUNT    = teq_pkg::ID_COUNT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire teq_pkg::teq_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output teq_pkg::teq_out_t       m_data
);

    // Controller and datapath talk only through these two bundles.
    teq_pkg::teq_cmd_t    cmd;
    teq_pkg::teq_status_t status;

    // Sequencer: idle/accept, execute, cancel loop, run loop.
    // The result register in the datapath lets a new item in while
    // the previous result still waits on m_ready.
    teq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // Sorted row of due time / id cells. Insert compares every cell
    // against the new due time in parallel and shifts the tail up;
    // pop and cancel shift down. Time register and result register live here.
    teq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_COUNT    (ID_COUNT)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // queue-changing commands are mutually exclusive
    logic [3:0] cmd_ops;
    assign cmd_ops = {cmd.load, cmd.apply, cmd.remove_one, cmd.pop};

    `TEQ_ASSERT_SAME(a_ops_exclusive, 1'b1, $onehot0(cmd_ops), "overlapping queue commands")
    `TEQ_ASSERT_SAME(a_pop_only_due, cmd.pop, status.head_due, "pop of an entry not yet due")
    `TEQ_ASSERT_SAME(a_emit_slot_free, cmd.emit, status.out_free, "result written over pending")
    `TEQ_ASSERT_NEXT(a_emit_shows, cmd.emit, m_valid, "emitted result not presented")

endmodule

`default_nettype wire

// ===== rtl/core/teq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module teq_datapath #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH,
    parameter int ID_COUNT    = teq_pkg::ID_COUNT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire teq_pkg::teq_in_t      s_data,
    input  wire logic                  m_ready,
    input  wire teq_pkg::teq_cmd_t     cmd,
    output teq_pkg::teq_status_t       status,
    output logic                       m_valid,
    output teq_pkg::teq_out_t          m_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    teq_pkg::teq_in_t                 item_reg, item_next;
    logic [teq_pkg::TIME_W-1:0]       when_reg, when_next;
    logic [teq_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [teq_pkg::TIME_W-1:0]       due_time_reg [QUEUE_DEPTH];
    logic [teq_pkg::TIME_W-1:0]       due_time_next [QUEUE_DEPTH];
    logic [teq_pkg::ID_W-1:0]         due_id_reg [QUEUE_DEPTH];
    logic [teq_pkg::ID_W-1:0]         due_id_next [QUEUE_DEPTH];
    logic                             hit_reg, hit_next;
    logic                             m_valid_reg, m_valid_next;
    teq_pkg::teq_out_t                m_data_reg, m_data_next;

    logic                   id_ok;
    logic                   full;
    logic                   ovf;
    logic [QUEUE_DEPTH-1:0] ge;      // entry sorts at or after the new one
    logic [QUEUE_DEPTH-1:0] match;
    logic [QUEUE_DEPTH-1:0] pre;     // at or past the first match

    assign id_ok = (32'(item_reg.event_id) < 32'(ID_COUNT));
    assign full  = (count_reg >= CNT_W'(QUEUE_DEPTH));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ge[i]    = (CNT_W'(i) >= count_reg) || (due_time_reg[i] >= when_reg);
            match[i] = (CNT_W'(i) < count_reg) && id_ok &&
                       (due_id_reg[i] == item_reg.event_id);
        end
        pre[0] = match[0];
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            pre[i] = pre[i-1] | match[i];
        end
    end

    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.head_due   = (count_reg != '0) && (due_time_reg[0] <= now_reg);
    assign status.second_due = (count_reg > CNT_W'(1)) && (due_time_reg[1] <= now_reg);
    assign status.match_any  = pre[QUEUE_DEPTH-1];

    always_comb begin
        item_next     = item_reg;
        when_next     = when_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        due_time_next = due_time_reg;
        due_id_next   = due_id_reg;
        hit_next      = hit_reg;
        ovf           = 1'b0;

        if (cmd.load) begin
            item_next = s_data;
            when_next = now_reg + s_data.delay;
            hit_next  = 1'b0;
        end

        if (cmd.apply) begin
            case (item_reg.kind)
                teq_pkg::KIND_TICK: begin
                    now_next = now_reg + teq_pkg::TIME_W'(item_reg.cycles);
                end
                teq_pkg::KIND_ADD: begin
                    if (id_ok && full) begin
                        ovf = 1'b1;
                    end else if (id_ok) begin
                        if (ge[0]) begin
                            due_time_next[0] = when_reg;
                            due_id_next[0]   = item_reg.event_id;
                        end
                        for (int i = 1; i < QUEUE_DEPTH; i++) begin
                            if (ge[i-1]) begin
                                due_time_next[i] = due_time_reg[i-1];
                                due_id_next[i]   = due_id_reg[i-1];
                            end else if (ge[i]) begin
                                due_time_next[i] = when_reg;
                                due_id_next[i]   = item_reg.event_id;
                            end
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                teq_pkg::KIND_SET: begin
                    now_next = item_reg.new_time;
                end
                teq_pkg::KIND_CLEAR: begin
                    now_next = '0;
                end
                teq_pkg::KIND_RESET: begin
                    now_next   = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end

        // drop the first matching entry, close the gap
        if (cmd.remove_one) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                if (pre[i]) begin
                    due_time_next[i] = due_time_reg[i+1];
                    due_id_next[i]   = due_id_reg[i+1];
                end
            end
            count_next = count_reg - CNT_W'(1);
            hit_next   = 1'b1;
        end

        if (cmd.pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                due_time_next[i] = due_time_reg[i+1];
                due_id_next[i]   = due_id_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (cmd.emit) begin
            m_valid_next            = 1'b1;
            m_data_next.fired_valid = cmd.fired;
            m_data_next.fired_id    = cmd.fired ? due_id_reg[0] : '0;
            m_data_next.last        = cmd.last;
            m_data_next.now_time    = now_next;
            m_data_next.next_time   = (count_next != '0) ? due_time_next[0] : '0;
            m_data_next.queue_count = teq_pkg::QCNT_W'(count_next);
            m_data_next.overflow    = ovf;
            m_data_next.cancel_hit  = (item_reg.kind == teq_pkg::KIND_CANCEL) && hit_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            now_reg     <= now_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        when_reg     <= when_next;
        due_time_reg <= due_time_next;
        due_id_reg   <= due_id_next;
        hit_reg      <= hit_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/teq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module teq_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    input  wire logic [teq_pkg::KIND_W-1:0]  s_kind,
    input  wire teq_pkg::teq_status_t        status,
    output logic                             s_ready,
    output teq_pkg::teq_cmd_t                cmd
);

    teq_pkg::teq_state_t               state_reg, state_next;
    logic [teq_pkg::RUN_CNT_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                              run_end;

    // burst cap reached or nothing else due after this pop
    assign run_end = (run_cnt_reg == teq_pkg::RUN_CNT_W'(teq_pkg::MAX_RESULTS - 1)) ||
                     !status.second_due;

    always_comb begin
        state_next   = state_reg;
        run_cnt_next = run_cnt_reg;
        case (state_reg)
            teq_pkg::ST_IDLE: begin
                run_cnt_next = '0;
                if (s_valid) begin
                    case (s_kind)
                        teq_pkg::KIND_CANCEL: state_next = teq_pkg::ST_CANCEL;
                        teq_pkg::KIND_RUN:    state_next = teq_pkg::ST_RUN;
                        default:              state_next = teq_pkg::ST_EXEC;
                    endcase
                end
            end
            teq_pkg::ST_EXEC: begin
                if (status.out_free) begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_CANCEL: begin
                if (!status.match_any && status.out_free) begin
                    state_next = teq_pkg::ST_IDLE;
                end
            end
            teq_pkg::ST_RUN: begin
                if (status.out_free) begin
                    if (status.head_due && !run_end) begin
                        run_cnt_next = run_cnt_reg + teq_pkg::RUN_CNT_W'(1);
                    end else begin
                        run_cnt_next = '0;
                        state_next   = teq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = teq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            teq_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            teq_pkg::ST_EXEC: begin
                if (status.out_free) begin
                    cmd.apply = 1'b1;
                    cmd.emit  = 1'b1;
                    cmd.last  = 1'b1;
                end
            end
            teq_pkg::ST_CANCEL: begin
                if (status.match_any) begin
                    cmd.remove_one = 1'b1;
                end else if (status.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                end
            end
            teq_pkg::ST_RUN: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.head_due) begin
                        cmd.pop   = 1'b1;
                        cmd.fired = 1'b1;
                        cmd.last  = run_end;
                    end else begin
                        cmd.last = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= teq_pkg::ST_IDLE;
            run_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sim/timed_event_queue_core_test.sv =====
`timescale 1ns / 1ps

module timed_event_queue_core_test;
    import teq_pkg::*;

    // kind 7 is not decoded by the package; the block must report status only
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
    localparam logic [CYC_W-1:0]  CYC_MAX     = {CYC_W{1'b1}};

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #1 aclk = ~aclk;

    // block ports; the driven inputs are known from time zero
    logic     s_valid = 1'b0;
    logic     s_ready;
    teq_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    teq_out_t m_data;

    timed_event_queue_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the scheduler: current time plus a sorted event list
    // ------------------------------------------------------------------
    logic [TIME_W-1:0] shadow_now;
    logic [TIME_W-1:0] shadow_due [QUEUE_DEPTH];
    logic [ID_W-1:0]   shadow_id  [QUEUE_DEPTH];
    int unsigned       shadow_count;

    // reports the block owes us, oldest first
    teq_out_t pending_reports[$];
    int       mismatches = 0;

    // receiver controls
    int rx_hold = 0;    // forced hold-off, counted down by the receiver
    bit rx_calm = 1'b0; // ready held high, no stalls

    function automatic void shadow_clear();
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            shadow_due[i] = '0;
            shadow_id[i]  = '0;
        end
        shadow_count = 0;
    endfunction

    // status snapshot of the shadow state at this point
    function automatic teq_out_t status_word(bit fired, logic [ID_W-1:0] id, bit lst,
                                             bit ovf, bit hit);
        teq_out_t r;
        r.fired_valid = fired;
        r.fired_id    = id;
        r.last        = lst;
        r.now_time    = shadow_now;
        r.next_time   = (shadow_count > 0) ? shadow_due[0] : '0;
        r.queue_count = QCNT_W'(shadow_count);
        r.overflow    = ovf;
        r.cancel_hit  = hit;
        return r;
    endfunction

    // apply one accepted command to the shadow and queue up its reports
    function automatic void predict_reports(teq_in_t it);
        logic [TIME_W-1:0] when;
        logic [ID_W-1:0]   fid;
        int unsigned       pos;
        int unsigned       wr;
        int                fired_n;
        bit                ovf;
        bit                hit;
        ovf = 1'b0;
        hit = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                shadow_now = shadow_now + TIME_W'(it.cycles);
            end
            KIND_ADD: begin
                if (shadow_count >= QUEUE_DEPTH) begin
                    ovf = 1'b1;
                end else begin
                    when = shadow_now + it.delay;
                    pos  = 0;
                    // new entry lands ahead of any entry due at the same time
                    while (pos < shadow_count && when > shadow_due[pos]) pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_due[i] = shadow_due[i-1];
                        shadow_id[i]  = shadow_id[i-1];
                    end
                    shadow_due[pos] = when;
                    shadow_id[pos]  = it.event_id;
                    shadow_count++;
                end
            end
            KIND_CANCEL: begin
                // every matching entry goes, order of the rest kept
                wr = 0;
                for (int rd = 0; rd < shadow_count; rd++) begin
                    if (shadow_id[rd] == it.event_id) begin
                        hit = 1'b1;
                    end else begin
                        shadow_due[wr] = shadow_due[rd];
                        shadow_id[wr]  = shadow_id[rd];
                        wr++;
                    end
                end
                shadow_count = wr;
            end
            KIND_RUN: begin
                fired_n = 0;
                while (fired_n < MAX_RESULTS && shadow_count > 0 &&
                       shadow_due[0] <= shadow_now) begin
                    fid = shadow_id[0];
                    for (int i = 1; i < shadow_count; i++) begin
                        shadow_due[i-1] = shadow_due[i];
                        shadow_id[i-1]  = shadow_id[i];
                    end
                    shadow_count--;
                    pending_reports.push_back(status_word(1'b1, fid, 1'b0, 1'b0, 1'b0));
                    fired_n++;
                end
                if (fired_n > 0) begin
                    pending_reports[$].last = 1'b1;
                    return;
                end
            end
            KIND_SET:   shadow_now = it.new_time;
            KIND_CLEAR: shadow_now = '0;
            KIND_RESET: begin
                shadow_now = '0;
                shadow_clear();
            end
            default: ;
        endcase
        pending_reports.push_back(status_word(1'b0, '0, 1'b1, ovf, hit));
    endfunction

    function automatic teq_in_t make_item(logic [KIND_W-1:0] kind, logic [CYC_W-1:0] cyc,
                                          logic [TIME_W-1:0] dly, logic [ID_W-1:0] id,
                                          logic [TIME_W-1:0] nt);
        teq_in_t it;
        it.kind     = kind;
        it.cycles   = cyc;
        it.delay    = dly;
        it.event_id = id;
        it.new_time = nt;
        return it;
    endfunction

    // gap lengths: a short range picked most of the time, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // random command, weighted toward add/tick/run so the queue gets deep
    function automatic teq_in_t rand_item();
        teq_in_t it;
        int      pick;
        it.cycles   = ($urandom_range(99) < 75) ? CYC_W'($urandom_range(0, 30))
                                                : CYC_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)      it.delay = TIME_W'($urandom_range(0, 40));
        else if (pick < 85) it.delay = rand_time();
        else                it.delay = TIME_MAX - TIME_W'($urandom_range(0, 20));
        // small id pool so cancels actually hit
        it.event_id = ($urandom_range(99) < 70) ? ID_W'($urandom_range(0, 7))
                                                : ID_W'($urandom_range(0, 63));
        it.new_time = ($urandom_range(99) < 60) ? rand_time()
                                                : TIME_W'($urandom_range(0, 100));
        pick = $urandom_range(99);
        if (pick < 38)      it.kind = KIND_ADD;
        else if (pick < 62) it.kind = KIND_TICK;
        else if (pick < 82) it.kind = KIND_RUN;
        else if (pick < 92) it.kind = KIND_CANCEL;
        else if (pick < 96) it.kind = KIND_SET;
        else if (pick < 98) it.kind = KIND_CLEAR;
        else                it.kind = KIND_RESET;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Called right after a rising edge. Valid is left high so a following
    // item can go back to back; tx_gap lowers it when idling.
    task automatic send_item(teq_in_t it);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_reports(it);
    endtask

    task automatic tx_gap(bit calm);
        int n;
        if (!calm && $urandom_range(99) < 40) begin
            n = pick_gap();
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // sender pauses until the block has delivered everything owed
    task automatic wait_all_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
                rx_hold--;
            end else if (rx_calm) begin
                m_ready <= 1'b1;
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(99) < 30) stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Report checker
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, logic [TIME_W-1:0] want,
                                      logic [TIME_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        teq_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("report with nothing outstanding: %0h", m_data);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                cmp_field("fired_valid", TIME_W'(want.fired_valid),
                          TIME_W'(m_data.fired_valid));
                cmp_field("fired_id",    TIME_W'(want.fired_id),
                          TIME_W'(m_data.fired_id));
                cmp_field("last",        TIME_W'(want.last), TIME_W'(m_data.last));
                cmp_field("now_time",    want.now_time,    m_data.now_time);
                cmp_field("next_time",   want.next_time,   m_data.next_time);
                cmp_field("queue_count", TIME_W'(want.queue_count),
                          TIME_W'(m_data.queue_count));
                cmp_field("overflow",    TIME_W'(want.overflow),
                          TIME_W'(m_data.overflow));
                cmp_field("cancel_hit",  TIME_W'(want.cancel_hit),
                          TIME_W'(m_data.cancel_hit));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Corner cases: empty run, time wrap, same-time ordering, multi-hit
    // cancel, cancel miss, clear, unused kind, full reset.
    task automatic test_directed();
        teq_in_t seq[$];
        seq.push_back(make_item(KIND_RESET,  '0, '0, '0, '0));
        seq.push_back(make_item(KIND_RUN,    '0, '0, '0, '0));        // nothing due
        seq.push_back(make_item(KIND_TICK,   CYC_MAX, '0, '0, '0));
        seq.push_back(make_item(KIND_TICK,   '0, TIME_MAX, 6'h3f, TIME_MAX));
        seq.push_back(make_item(KIND_ADD,    '0, '0, 6'd0, '0));      // due now
        seq.push_back(make_item(KIND_ADD,    '0, TIME_MAX, 6'd63, '0)); // wraps to now-1
        seq.push_back(make_item(KIND_ADD,    '0, '0, 6'd9, '0));      // ties with id 0
        seq.push_back(make_item(KIND_CANCEL, '0, '0, 6'd40, '0));     // miss
        seq.push_back(make_item(KIND_RUN,    '0, '0, '0, '0));        // fires 63, 9, 0
        seq.push_back(make_item(KIND_SET,    '0, '0, '0, TIME_MAX));
        seq.push_back(make_item(KIND_ADD,    '0, 64'd1, 6'd5, '0));   // due wraps to 0
        seq.push_back(make_item(KIND_ADD,    '0, 64'd3, 6'd5, '0));
        seq.push_back(make_item(KIND_ADD,    '0, 64'd2, 6'd6, '0));
        seq.push_back(make_item(KIND_ADD,    '0, '0, 6'd5, '0));
        seq.push_back(make_item(KIND_CANCEL, '0, '0, 6'd5, '0));      // removes three
        seq.push_back(make_item(KIND_CANCEL, '0, '0, 6'd5, '0));      // now a miss
        seq.push_back(make_item(KIND_TICK,   31'd1, '0, '0, '0));     // now wraps to 0
        seq.push_back(make_item(KIND_RUN,    '0, '0, '0, '0));        // head due at 1
        seq.push_back(make_item(KIND_TICK,   31'd5, '0, '0, '0));
        seq.push_back(make_item(KIND_RUN,    '0, '0, '0, '0));
        seq.push_back(make_item(KIND_ADD,    '0, 64'd10, 6'd3, '0));
        seq.push_back(make_item(KIND_CLEAR,  CYC_MAX, TIME_MAX, 6'h3f, TIME_MAX));
        seq.push_back(make_item(KIND_UNUSED, CYC_MAX, TIME_MAX, 6'h2a, TIME_MAX));
        seq.push_back(make_item(KIND_RESET,  '0, '0, '0, '0));
        seq.push_back(make_item(KIND_RUN,    '0, '0, '0, '0));
        foreach (seq[i]) begin
            send_item(seq[i]);
            tx_gap(1'b0);
        end
        wait_all_done();
    endtask

    // Receiver holds off at the start, so the block stalls on a pending result;
    // the queue is then filled past full and drained by one full-length run burst.
    task automatic test_backpressure();
        rx_hold = 300;
        send_item(make_item(KIND_RESET, '0, '0, '0, '0));
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(make_item(KIND_ADD, '0, TIME_W'($urandom_range(0, 20)),
                                ID_W'($urandom_range(0, 63)), '0));
        send_item(make_item(KIND_ADD, '0, 64'd1, 6'd12, '0));        // dropped, overflow
        send_item(make_item(KIND_TICK, 31'd100, '0, '0, '0));
        send_item(make_item(KIND_RUN, '0, '0, '0, '0));              // sixteen fire
        send_item(make_item(KIND_RUN, '0, '0, '0, '0));
        wait_all_done();
    endtask

    // Random commands: a back-to-back stretch first, a full pause midway.
    task automatic test_random(int count);
        bit calm;
        for (int i = 0; i < count; i++) begin
            calm    = (i < count / 4);
            rx_calm = calm;
            if (i == count / 2) wait_all_done();
            send_item(rand_item());
            tx_gap(calm);
        end
        rx_calm = 1'b0;
    endtask

    initial begin
        shadow_now = '0;
        shadow_clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random(64);

        wait_all_done();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("timed_event_queue_core_test: PASS");
        end else begin
            $display("timed_event_queue_core_test: FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timed_event_queue_core_test: FAIL");
        $finish;
    end

endmodule
